// ----- sv/fca_pkg.sv -----
// ----------------------------------------------------------------------------
// fca_pkg: shared types, constants and helpers
// Payload structs, register codes and bit-level helpers used by the fused
// five-column axpy datapath.
// ----------------------------------------------------------------------------
package fca_pkg;

    localparam int NUM_CARRIED = 5;
    localparam int FUSE_WIDTH_DEF = 5;
    localparam int FMA_LAT = 8;

    localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;
    localparam logic [62:0] INF_MAG = 63'h7FF0_0000_0000_0000;
    localparam logic [63:0] NEG_ZERO = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        CFG_ALPHA = 3'd0,
        CFG_X0    = 3'd1,
        CFG_X1    = 3'd2,
        CFG_X2    = 3'd3,
        CFG_X3    = 3'd4,
        CFG_X4    = 3'd5,
        CFG_COLS  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [63:0] y_in;
        logic [63:0] a_col0;
        logic [63:0] a_col1;
        logic [63:0] a_col2;
        logic [63:0] a_col3;
        logic [63:0] a_col4;
        logic        last_row;
    } in_t;

    typedef struct packed {
        logic [63:0] y_out;
        logic        last_out;
    } out_t;

    // Side information that rides along an FMA pipeline
    typedef struct packed {
        logic        spec;
        logic [63:0] res;
        logic        sp;
        logic        sc;
        logic        cz;
    } fma_meta_t;

    function automatic logic [6:0] msb128(input logic [127:0] x);
        logic [6:0] k;
        k = '0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) k = 7'(i);
        end
        return k;
    endfunction

    // Right shift by a non-negative amount, OR every lost bit into bit 0
    function automatic logic [127:0] sticky_shr(input logic [127:0] x,
                                                input logic [13:0] n);
        logic [127:0] r;
        logic [127:0] mask;
        if (n >= 14'd128) begin
            r = {127'b0, |x};
        end else begin
            mask = ~({128{1'b1}} << n[6:0]);
            r = x >> n[6:0];
            r[0] = r[0] | (|(x & mask));
        end
        return r;
    endfunction

    function automatic logic [63:0] col_sel(input in_t r, input logic [2:0] j);
        logic [63:0] v;
        case (j)
            3'd0:    v = r.a_col0;
            3'd1:    v = r.a_col1;
            3'd2:    v = r.a_col2;
            3'd3:    v = r.a_col3;
            3'd4:    v = r.a_col4;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- sv/fca_fma.sv -----
// ----------------------------------------------------------------------------
// fca_fma: pipelined binary64 fused multiply-add
// Computes a*b + c with one rounding (nearest even) over eight register
// stages; act low passes c through. A row tag rides along with each item.
// ----------------------------------------------------------------------------
module fca_fma
    import fca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        en,
    input  logic        in_valid,
    input  logic [63:0] a,
    input  logic [63:0] b,
    input  logic [63:0] c,
    input  logic        act,
    input  in_t         tag_in,
    output logic        out_valid,
    output logic [63:0] res,
    output in_t         tag_out
);

    logic [FMA_LAT-1:0] v_reg;
    in_t                tag_reg [FMA_LAT];
    fma_meta_t          m_reg   [FMA_LAT-1];

    // stage 1
    logic [63:0] pp_ll_reg, pp_ll_next;
    logic [52:0] pp_lh_reg, pp_lh_next, pp_hl_reg, pp_hl_next;
    logic [41:0] pp_hh_reg, pp_hh_next;
    logic signed [13:0] ep1_reg, ep1_next, eq1_reg, eq1_next;
    logic [52:0] mc1_reg, mc1_next;
    fma_meta_t   m1_next;
    // stage 2
    logic [105:0] p2_reg, p2_next;
    logic signed [13:0] ep2_reg, eq2_reg;
    logic [52:0] mc2_reg;
    // stage 3
    logic [127:0] p3_reg, p3_next, q3_reg, q3_next;
    logic signed [13:0] ep3_reg, ep3_next, eq3_reg, eq3_next;
    // stage 4
    logic [127:0] p4_reg, p4_next, q4_reg, q4_next;
    logic signed [13:0] e4_reg, e4_next;
    // stage 5
    logic [127:0] s5_reg, s5_next;
    logic signed [13:0] e5_reg;
    logic        sg5_reg, sg5_next;
    fma_meta_t   m5_next;
    // stage 6
    logic [127:0] s6_reg;
    logic signed [13:0] e6_reg, sh6_reg, sh6_next;
    logic        sg6_reg;
    // stage 7
    logic [52:0] q7_reg, q7_next;
    logic        inc7_reg, inc7_next, sg7_reg;
    logic [10:0] fld7_reg, fld7_next;
    logic        ovf7_reg, ovf7_next;
    fma_meta_t   m7_next;
    // stage 8
    logic [63:0] res8_reg, res8_next;

    always_comb
    begin
        logic sa, sb, sc, sp;
        logic [10:0] ea, eb, ec;
        logic [51:0] fa, fb, fc;
        logic az, bz, cz, a_inf, b_inf, c_inf, any_nan;
        logic [52:0] ma, mb;
        logic [6:0] kp, kq, ks;
        logic signed [13:0] diff, sub, kk, fld;
        logic [127:0] mask, rem, half, qq;
        logic [53:0] qr;

        sa = a[63]; sb = b[63]; sc = c[63]; sp = sa ^ sb;
        ea = a[62:52]; eb = b[62:52]; ec = c[62:52];
        fa = a[51:0]; fb = b[51:0]; fc = c[51:0];
        az = (ea == '0) && (fa == '0);
        bz = (eb == '0) && (fb == '0);
        cz = (ec == '0) && (fc == '0);
        a_inf = (ea == '1) && (fa == '0);
        b_inf = (eb == '1) && (fb == '0);
        c_inf = (ec == '1) && (fc == '0);
        any_nan = ((ea == '1) && (fa != '0)) || ((eb == '1) && (fb != '0))
                  || ((ec == '1) && (fc != '0));

        m1_next.sp = sp; m1_next.sc = sc; m1_next.cz = cz;
        m1_next.spec = 1'b1; m1_next.res = c;
        priority if (!act) begin
            m1_next.res = c;
        end else if (any_nan) begin
            m1_next.res = QNAN_BITS;
        end else if (a_inf || b_inf) begin
            if (az || bz || (c_inf && (sc != sp))) m1_next.res = QNAN_BITS;
            else m1_next.res = {sp, INF_MAG};
        end else if (c_inf) begin
            m1_next.res = c;
        end else if (az || bz) begin
            m1_next.res = cz ? {sp & sc, 63'b0} : c;
        end else begin
            m1_next.spec = 1'b0;
        end

        ma = {ea != '0, fa};
        mb = {eb != '0, fb};
        pp_ll_next = ma[31:0] * mb[31:0];
        pp_lh_next = ma[31:0] * mb[52:32];
        pp_hl_next = ma[52:32] * mb[31:0];
        pp_hh_next = ma[52:32] * mb[52:32];
        ep1_next = $signed({3'b0, (ea != '0) ? ea : 11'd1})
                 + $signed({3'b0, (eb != '0) ? eb : 11'd1}) - 14'sd2150;
        eq1_next = $signed({3'b0, (ec != '0) ? ec : 11'd1}) - 14'sd1075;
        mc1_next = {ec != '0, fc};

        // stage 2: sum partial products
        p2_next = (106'(pp_hh_reg) << 64) + ((106'(pp_lh_reg) + 106'(pp_hl_reg)) << 32)
                + 106'(pp_ll_reg);

        // stage 3: normalize both operands to bit 125
        kp = msb128({22'b0, p2_reg});
        kq = msb128({75'b0, mc2_reg});
        p3_next = {22'b0, p2_reg} << (7'd125 - kp);
        q3_next = {75'b0, mc2_reg} << (7'd125 - kq);
        ep3_next = ep2_reg - $signed({7'b0, 7'd125 - kp});
        eq3_next = eq2_reg - $signed({7'b0, 7'd125 - kq});

        // stage 4: align the smaller operand
        diff = ep3_reg - eq3_reg;
        p4_next = p3_reg;
        q4_next = q3_reg;
        e4_next = ep3_reg;
        priority if (m_reg[2].cz) begin
            q4_next = '0;
        end else if (diff >= 0) begin
            q4_next = sticky_shr(q3_reg, diff);
        end else begin
            p4_next = sticky_shr(p3_reg, -diff);
            e4_next = eq3_reg;
        end

        // stage 5: add or subtract magnitudes
        m5_next = m_reg[3];
        s5_next = p4_reg + q4_reg;
        sg5_next = m_reg[3].sp;
        priority if (m_reg[3].sp == m_reg[3].sc) begin
            s5_next = p4_reg + q4_reg;
        end else if (p4_reg == q4_reg) begin
            s5_next = '0;
            if (!m_reg[3].spec) begin
                m5_next.spec = 1'b1;
                m5_next.res = '0;
            end
        end else if (p4_reg > q4_reg) begin
            s5_next = p4_reg - q4_reg;
        end else begin
            s5_next = q4_reg - p4_reg;
            sg5_next = m_reg[3].sc;
        end

        // stage 6: rounding position
        ks = msb128(s5_reg);
        kk = $signed({7'b0, ks}) - 14'sd52;
        sub = -14'sd1074 - e5_reg;
        sh6_next = (sub > kk) ? sub : kk;

        // stage 7: shift and round decision
        m7_next = m_reg[5];
        q7_next = '0;
        inc7_next = 1'b0;
        mask = '0; rem = '0; half = '0; qq = '0;
        fld = e6_reg + sh6_reg + 14'sd1074;
        fld7_next = fld[10:0];
        ovf7_next = fld > 14'sd2045;
        priority if (sh6_reg <= 0) begin
            q7_next = 53'(s6_reg[63:0] << 7'(-sh6_reg));
        end else if (sh6_reg >= 14'sd128) begin
            if (!m_reg[5].spec) begin
                m7_next.spec = 1'b1;
                m7_next.res = {sg6_reg, 63'b0};
            end
        end else begin
            qq = s6_reg >> sh6_reg[6:0];
            mask = ({{127{1'b0}}, 1'b1} << sh6_reg[6:0]) - 128'd1;
            rem = s6_reg & mask;
            half = {{127{1'b0}}, 1'b1} << (sh6_reg[6:0] - 7'd1);
            q7_next = qq[52:0];
            inc7_next = (rem > half) || ((rem == half) && qq[0]);
        end

        // stage 8: pack
        qr = {1'b0, q7_reg} + {53'b0, inc7_reg};
        priority if (m_reg[6].spec) begin
            res8_next = m_reg[6].res;
        end else if (ovf7_reg) begin
            res8_next = {sg7_reg, INF_MAG};
        end else begin
            res8_next = {sg7_reg, 63'({fld7_reg, 52'b0} + {10'b0, qr})};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[FMA_LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < FMA_LAT; i++) tag_reg[i] <= tag_reg[i-1];
            m_reg[0] <= m1_next;
            m_reg[1] <= m_reg[0];
            m_reg[2] <= m_reg[1];
            m_reg[3] <= m_reg[2];
            m_reg[4] <= m5_next;
            m_reg[5] <= m_reg[4];
            m_reg[6] <= m7_next;
            pp_ll_reg <= pp_ll_next; pp_lh_reg <= pp_lh_next;
            pp_hl_reg <= pp_hl_next; pp_hh_reg <= pp_hh_next;
            ep1_reg <= ep1_next; eq1_reg <= eq1_next; mc1_reg <= mc1_next;
            p2_reg <= p2_next; ep2_reg <= ep1_reg; eq2_reg <= eq1_reg; mc2_reg <= mc1_reg;
            p3_reg <= p3_next; q3_reg <= q3_next; ep3_reg <= ep3_next; eq3_reg <= eq3_next;
            p4_reg <= p4_next; q4_reg <= q4_next; e4_reg <= e4_next;
            s5_reg <= s5_next; e5_reg <= e4_reg; sg5_reg <= sg5_next;
            s6_reg <= s5_reg; e6_reg <= e5_reg; sh6_reg <= sh6_next; sg6_reg <= sg5_reg;
            q7_reg <= q7_next; inc7_reg <= inc7_next; sg7_reg <= sg6_reg;
            fld7_reg <= fld7_next; ovf7_reg <= ovf7_next;
            res8_reg <= res8_next;
        end
    end

    assign out_valid = v_reg[FMA_LAT-1];
    assign res = res8_reg;
    assign tag_out = tag_reg[FMA_LAT-1];

endmodule

// ----- sv/fused_five_column_axpy.sv -----
// ----------------------------------------------------------------------------
// fused_five_column_axpy: binary64 fused axpy over up to five columns
// y_out = y_in + sum_j (alpha*x_j)*a_colj as a chain of fused multiply-adds.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------
//  in      | in  | in_valid/in_stall  | in_t  : y_in, a_col0..4, last_row
//  out     | out | out_valid/out_stall| out_t : y_out, last_out
//  cfg     | in  | cfg_valid/cfg_ready| cfg_index (3b), cfg_data (64b)
//
//  One row per cycle sustained while in_stall is low; a row passes through
//  each column's FMA unit in turn and then into the output register.
//  Each column owns an 8-stage FMA unit; the whole chain moves on one enable.
//  A skid register behind the output register takes one more transfer while
//  out_stall is high; the chain and the input hold while the skid is occupied.
//  After any config write the input stalls while the column coefficients
//  alpha*x_j settle in their own FMA units.
//  Reset clears valid bits and config to alpha=0, x=0, columns_in_use=5.
// ----------------------------------------------------------------------------
module fused_five_column_axpy
    import fca_pkg::*;
#(
    parameter int FUSE_WIDTH = FUSE_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int NS = (FUSE_WIDTH < NUM_CARRIED) ? FUSE_WIDTH : NUM_CARRIED;
    localparam int CW = $clog2(FMA_LAT + 2);

    logic [63:0] alpha_reg;
    logic [63:0] x_reg [NUM_CARRIED];
    logic [2:0]  cols_reg;
    logic [CW-1:0] settle_reg;

    logic        out_valid_reg, skid_valid_reg;
    out_t        out_reg, skid_reg;

    logic        adv;
    logic        alpha_nz;
    logic [2:0]  cols_eff;

    logic        v_chain [NS+1];
    logic [63:0] y_chain [NS+1];
    in_t         row_chain [NS+1];
    logic [63:0] coef [NS];

    assign cfg_ready = 1'b1;
    assign adv = !skid_valid_reg;
    assign in_stall = skid_valid_reg || (settle_reg != '0);
    assign alpha_nz = (alpha_reg & ~NEG_ZERO) != '0;
    assign cols_eff = (cols_reg > 3'(NS)) ? 3'(NS) : cols_reg;

    // Hold configuration; restart the settle count on every write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            alpha_reg <= '0;
            for (int i = 0; i < NUM_CARRIED; i++) x_reg[i] <= '0;
            cols_reg <= 3'd5;
            settle_reg <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                settle_reg <= CW'(FMA_LAT + 1);
                case (cfg_idx_t'(cfg_index))
                    CFG_ALPHA: alpha_reg <= cfg_data;
                    CFG_X0:    x_reg[0] <= cfg_data;
                    CFG_X1:    x_reg[1] <= cfg_data;
                    CFG_X2:    x_reg[2] <= cfg_data;
                    CFG_X3:    x_reg[3] <= cfg_data;
                    CFG_X4:    x_reg[4] <= cfg_data;
                    CFG_COLS:  cols_reg <= cfg_data[2:0];
                    default:   ;
                endcase
            end else if (settle_reg != '0) begin
                settle_reg <= settle_reg - CW'(1);
            end
        end
    end

    assign v_chain[0] = in_valid && !in_stall;
    assign y_chain[0] = in_data.y_in;
    assign row_chain[0] = in_data;

    genvar j;
    generate
        for (j = 0; j < NS; j++) begin : g_col
            logic  cv;
            in_t   ctag;
            // Coefficient unit: alpha*x_j rounded once, recomputed every cycle
            fca_fma u_coef (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (1'b1),
                .in_valid  (1'b1),
                .a         (alpha_reg),
                .b         (x_reg[j]),
                .c         (NEG_ZERO),
                .act       (1'b1),
                .tag_in    ('0),
                .out_valid (cv),
                .res       (coef[j]),
                .tag_out   (ctag)
            );

            // Column update: y += coef_j * a_colj when active, else y passes through
            fca_fma u_col (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (adv),
                .in_valid  (v_chain[j]),
                .a         (coef[j]),
                .b         (col_sel(row_chain[j], 3'(j))),
                .c         (y_chain[j]),
                .act       (alpha_nz && (3'(j) < cols_eff)),
                .tag_in    (row_chain[j]),
                .out_valid (v_chain[j+1]),
                .res       (y_chain[j+1]),
                .tag_out   (row_chain[j+1])
            );
        end
    endgenerate

    // Output register plus skid: push on advance, pop on unstalled transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!out_valid_reg || !out_stall) begin
                out_valid_reg <= skid_valid_reg || (adv && v_chain[NS]);
                skid_valid_reg <= 1'b0;
            end else if (adv && v_chain[NS]) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall) begin
            if (skid_valid_reg) out_reg <= skid_reg;
            else out_reg <= '{y_out: y_chain[NS], last_out: row_chain[NS].last_row};
        end else if (adv && v_chain[NS]) begin
            skid_reg <= '{y_out: y_chain[NS], last_out: row_chain[NS].last_row};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_reg;

    // The skid only ever holds a result behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while output register is empty");

    // A config write blocks new rows until the coefficients settle
    a_cfg_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> in_stall)
        else $error("row accepted right after a config write");

    // A stalled output keeps the skid entry
    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_stall) |=> skid_valid_reg)
        else $error("skid entry dropped under stall");

endmodule
